/* src/frf_pkg.sv */
// Shared types, constants and the CRC byte fold for the frame repetition filter.
// Used by frf_ctrl, frf_dp and frame_repetition_filter_core; depends on nothing.
package frf_pkg;

  localparam logic [15:0] CRC_INIT       = 16'h1D0F;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_MSB        = 16'h8000;
  localparam logic [7:0]  FIRST_BYTE_SET = 8'b0010_0000;
  localparam logic [8:0]  INDEX_MAX      = 9'd511;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;
  localparam int ENT_W      = 64;
  localparam int ENT_OUT_W  = 5;
  localparam int ENT_OUT_MAX = 31;

  typedef struct packed {
    logic fold;
    logic start;
    logic clear;
    logic scan;
    logic commit;
  } frf_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } frf_sts_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0] value);
    logic [15:0] crc;
    crc = crc_in ^ {value, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((crc & CRC_MSB) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* src/frf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the sender table; no dependencies.
module frf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/frf_ctrl.sv */
// Controller state machine: accepts requests, sequences the table walk and commit.
// Depends on frf_pkg for the command and status structs.
module frf_ctrl
  import frf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  input  logic     in_cmd,
  output logic     in_tready,
  input  frf_sts_t sts,
  output frf_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;
  logic   acc;

  assign acc = in_tvalid && rdy_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_cmd) begin
            cmd.clear = 1'b1;
          end else if (!in_tlast) begin
            cmd.fold = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    rdy_nxt = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  assign in_tready = rdy_r;

endmodule

/* src/frf_dp.sv */
// Datapath: CRC accumulator, sender table walk, slot choice and result register.
// Depends on frf_pkg and frf_ram; driven by commands from frf_ctrl.
module frf_dp
  import frf_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  frf_cmd_t              cmd,
  output frf_sts_t              sts,
  input  logic [7:0]            data_byte,
  input  logic [8:0]            frame_length,
  input  logic [15:0]           sender,
  input  logic [31:0]           now_ms,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_repeated,
  output logic [15:0]           out_fingerprint,
  output logic [ENT_OUT_W-1:0]  out_entries
);

  logic [15:0]          crc_r;
  logic [8:0]           idx_r;
  logic [15:0]          sender_r;
  logic [31:0]          now_r;
  logic [15:0]          fp_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     match_r, match_nxt;
  logic                 seen_r, seen_nxt;
  logic                 free_fnd_r, free_fnd_nxt;
  logic [IDX_W-1:0]     free_r, free_nxt;
  logic [31:0]          max_age_r, max_age_nxt;
  logic [IDX_W-1:0]     oldest_r, oldest_nxt;
  logic [ENTRIES-1:0]   used_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 out_vld_r;
  logic                 out_rep_r;
  logic [15:0]          out_fp_r;
  logic [ENT_OUT_W-1:0] out_ent_r;

  logic [7:0]           fold_val;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic [15:0]          ent_sender;
  logic [15:0]          ent_fp;
  logic [31:0]          ent_time;
  logic [31:0]          age;
  logic [IDX_W-1:0]     slot;
  logic [CNT_W-1:0]     cnt_new;

  assign fold_val = (idx_r == 9'd0) ? (data_byte | FIRST_BYTE_SET) : data_byte;

  assign rd_en   = cmd.scan && (int'(rd_cnt_r) < ENTRIES);
  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  frf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (slot),
    .wr_data ({now_r, fp_r, sender_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_sender = rd_data[15:0];
  assign ent_fp     = rd_data[31:16];
  assign ent_time   = rd_data[63:32];
  assign age        = now_r - ent_time;

  always_comb begin
    found_nxt    = found_r;
    match_nxt    = match_r;
    seen_nxt     = seen_r;
    free_fnd_nxt = free_fnd_r;
    free_nxt     = free_r;
    max_age_nxt  = max_age_r;
    oldest_nxt   = oldest_r;
    if (cmp_vld_r && !found_r) begin
      if (!used_r[cmp_idx_r]) begin
        if (!free_fnd_r) begin
          free_fnd_nxt = 1'b1;
          free_nxt     = cmp_idx_r;
        end
      end else if (ent_sender == sender_r) begin
        found_nxt = 1'b1;
        match_nxt = cmp_idx_r;
        seen_nxt  = (ent_fp == fp_r);
      end else if (age > max_age_r) begin
        max_age_nxt = age;
        oldest_nxt  = cmp_idx_r;
      end
    end
  end

  assign slot    = found_r ? match_r : (free_fnd_r ? free_r : oldest_r);
  assign cnt_new = used_r[slot] ? cnt_r : cnt_r + CNT_W'(1);

  assign sts.scan_end = cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      idx_r      <= 9'd0;
      rd_cnt_r   <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      free_fnd_r <= 1'b0;
      used_r     <= '0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r  <= rd_en;
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (cmd.fold) begin
        if (idx_r < frame_length) begin
          crc_r <= crc_fold(crc_r, fold_val);
        end
        if (idx_r != INDEX_MAX) begin
          idx_r <= idx_r + 9'd1;
        end
      end
      if (cmd.start) begin
        crc_r      <= CRC_INIT;
        idx_r      <= 9'd0;
        rd_cnt_r   <= '0;
        found_r    <= 1'b0;
        free_fnd_r <= 1'b0;
      end else begin
        found_r    <= found_nxt;
        free_fnd_r <= free_fnd_nxt;
      end
      if (cmd.clear) begin
        used_r <= '0;
        cnt_r  <= '0;
      end
      if (cmd.commit) begin
        used_r[slot] <= 1'b1;
        cnt_r        <= cnt_new;
        out_vld_r    <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_addr;
    match_r   <= match_nxt;
    free_r    <= free_nxt;
    if (cmd.start) begin
      sender_r  <= sender;
      now_r     <= now_ms;
      fp_r      <= crc_r;
      seen_r    <= 1'b0;
      max_age_r <= 32'd0;
      oldest_r  <= '0;
    end else begin
      seen_r    <= seen_nxt;
      max_age_r <= max_age_nxt;
      oldest_r  <= oldest_nxt;
    end
    if (cmd.commit) begin
      out_rep_r <= found_r && seen_r;
      out_fp_r  <= fp_r;
      out_ent_r <= (int'(cnt_new) > ENT_OUT_MAX) ? ENT_OUT_W'(ENT_OUT_MAX)
                                                 : ENT_OUT_W'(cnt_new);
    end
  end

  assign out_tvalid      = out_vld_r;
  assign out_repeated    = out_rep_r;
  assign out_fingerprint = out_fp_r;
  assign out_entries     = out_ent_r;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_vld_r || out_tready))
    else $error("commit overwrites an untaken result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= ENTRIES)
    else $error("used count exceeds table size");

  a_clear_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (cnt_r == '0) && (used_r == '0))
    else $error("clear left used entries");

endmodule

/* src/frame_repetition_filter_core.sv */
// Frame repetition filter. Frame bytes and clear requests arrive on the in_ stream;
// each frame byte carrying tlast ends a frame and yields one result on the out_ stream
// (repeated flag, CRC-16 fingerprint, used entry count). Frame bytes and clear
// requests are taken back to back. A last byte drops in_tready while the controller
// walks the sender table RAM, one entry per cycle through its single read port, and
// then commits the result; commit also waits while an earlier result is not taken.
// Depends on frf_pkg, frf_ctrl, frf_dp and frf_ram.
module frame_repetition_filter_core
  import frf_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // data_byte, frame_length, sender, now_ms
  input  logic                  in_tlast,
  input  logic [0:0]            in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // repeated, frame_fingerprint, entries_in_use
);

  frf_cmd_t             cmd;
  frf_sts_t             sts;
  logic                 out_repeated;
  logic [15:0]          out_fingerprint;
  logic [ENT_OUT_W-1:0] out_entries;

  frf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_cmd    (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .data_byte       (in_tdata[7:0]),
    .frame_length    (in_tdata[16:8]),
    .sender          (in_tdata[32:17]),
    .now_ms          (in_tdata[64:33]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_repeated    (out_repeated),
    .out_fingerprint (out_fingerprint),
    .out_entries     (out_entries)
  );

  assign out_tdata = {2'b00, out_entries, out_fingerprint, out_repeated};

endmodule

/* sim/frame_repetition_filter_core_tb.sv */
// Self-checking testbench for frame_repetition_filter_core: directed and random frames on
// the in_ stream, results on the out_ stream compared against a built-in table predictor.
// Depends on frf_pkg and the frame_repetition_filter_core RTL.
module frame_repetition_filter_core_tb
  import frf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_SIZE  = 16;
  localparam int          ITEM_TARGET = 1350;
  localparam int          LONG_HOLD   = 300;
  localparam logic [15:0] FP_SEED     = 16'h1D0F;
  localparam logic [15:0] FP_POLY     = 16'h1021;
  localparam logic [8:0]  POS_LIMIT   = 9'd511;
  localparam bit          REQ_BYTE    = 1'b0;
  localparam bit          REQ_CLEAR   = 1'b1;

  typedef struct {
    logic       repeated;
    logic [15:0] fingerprint;
    logic [4:0]  used_count;
  } verdict_t;

  class repetition_predictor;
    logic [15:0] running_crc;
    logic [8:0]  byte_pos;
    logic [15:0] slot_sender[TABLE_SIZE];
    logic [15:0] slot_fp[TABLE_SIZE];
    logic [31:0] slot_stamp[TABLE_SIZE];
    bit          slot_used[TABLE_SIZE];
    verdict_t    pending_verdicts[$];
    int          failures;

    function new();
      running_crc = FP_SEED;
      byte_pos = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      failures = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] value);
      logic [15:0] r;
      logic        msb;
      r = acc ^ {value, 8'h00};
      for (int b = 0; b < 8; b++) begin
        msb = r[15];
        r = r << 1;
        if (msb) r = r ^ FP_POLY;
      end
      return r;
    endfunction

    function void note_request(bit clear, logic [7:0] data, bit last, logic [8:0] flen,
                               logic [15:0] sender, logic [31:0] now);
      int          slot;
      int          oldest;
      int          n;
      bit          found_slot;
      bit          matched;
      logic [7:0]  folded;
      logic [31:0] age_i;
      logic [31:0] age_old;
      verdict_t    v;
      if (clear) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        return;
      end
      if (!last && byte_pos < flen) begin
        folded = data;
        if (byte_pos == 9'd0) folded[5] = 1'b1;
        running_crc = crc_step(running_crc, folded);
      end
      if (!last) begin
        if (byte_pos != POS_LIMIT) byte_pos++;
        return;
      end
      slot = 0;
      oldest = 0;
      found_slot = 1'b0;
      matched = 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (!slot_used[i]) begin
          if (!found_slot) begin
            slot = i;
            found_slot = 1'b1;
          end
          continue;
        end
        if (slot_sender[i] == sender) begin
          matched = (slot_fp[i] == running_crc);
          slot = i;
          found_slot = 1'b1;
          break;
        end
        age_i = now - slot_stamp[i];
        age_old = now - slot_stamp[oldest];
        if (age_i > age_old) oldest = i;
      end
      if (!found_slot) slot = oldest;
      slot_sender[slot] = sender;
      slot_fp[slot] = running_crc;
      slot_stamp[slot] = now;
      slot_used[slot] = 1'b1;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i]) n++;
      if (n > 31) n = 31;
      v.repeated = matched;
      v.fingerprint = running_crc;
      v.used_count = n[4:0];
      pending_verdicts.push_back(v);
      running_crc = FP_SEED;
      byte_pos = '0;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result, tdata %h", word);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (word[0] !== want.repeated) begin
        $error("repeated: expected %0d, actual %0d", want.repeated, word[0]);
        failures++;
      end
      if (word[16:1] !== want.fingerprint) begin
        $error("frame_fingerprint: expected %h, actual %h", want.fingerprint, word[16:1]);
        failures++;
      end
      if (word[21:17] !== want.used_count) begin
        $error("entries_in_use: expected %0d, actual %0d", want.used_count, word[21:17]);
        failures++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  repetition_predictor tracker = new();
  bit                  idle_on = 1'b1;
  bit                  hold_req = 1'b0;
  int                  sent = 0;
  logic [7:0]          payloads[4][16];
  logic [15:0]         sender_pool[24];

  frame_repetition_filter_core #(.ENTRIES(TABLE_SIZE)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  task automatic send_request(bit clear, logic [7:0] data, bit last, logic [8:0] flen,
                              logic [15:0] sender, logic [31:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= clear;
    in_tlast <= last;
    in_tdata <= {7'd0, now, sender, flen, data};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(clear, data, last, flen, sender, now);
    sent++;
  endtask

  task automatic send_frame(logic [15:0] sender, logic [31:0] now, int body, int lib,
                            logic [8:0] flen);
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(0, 59) == 0)
        send_request(REQ_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)), 9'($urandom),
                     16'($urandom), $urandom);
      send_request(REQ_BYTE, (lib < 0) ? 8'($urandom) : payloads[lib][k % 16], 1'b0, flen,
                   16'($urandom), $urandom);
    end
    send_request(REQ_BYTE, 8'($urandom), 1'b1, flen, sender, now);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit          held;
    bit          paused;
    bit          long_done;
    int          body;
    int          lib;
    int          pick;
    logic [8:0]  flen;
    logic [31:0] stamp;
    logic [15:0] who;
    held = 1'b0;
    paused = 1'b0;
    long_done = 1'b0;
    stamp = 32'hFFFF_FE00;
    foreach (payloads[i, j]) payloads[i][j] = 8'($urandom);
    foreach (sender_pool[i]) sender_pool[i] = 16'($urandom);
    sender_pool[0] = 16'h0000;
    sender_pool[1] = 16'hFFFF;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    in_tuser <= REQ_BYTE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first byte with bit 5 low, full declared length, extreme sender and time
    send_request(REQ_BYTE, 8'h00, 1'b0, 9'd511, 16'h0000, 32'h0000_0000);
    send_request(REQ_BYTE, 8'hFF, 1'b0, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_BYTE, 8'hDF, 1'b1, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    // same sender and content, first byte already has bit 5 set
    send_request(REQ_BYTE, 8'h20, 1'b0, 9'd511, 16'h0000, 32'h0000_0000);
    send_request(REQ_BYTE, 8'hFF, 1'b0, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_BYTE, 8'h00, 1'b1, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    // zero declared length
    send_request(REQ_BYTE, 8'hA5, 1'b0, 9'd0, 16'h0000, 32'h0000_0000);
    send_request(REQ_BYTE, 8'h5A, 1'b1, 9'd0, 16'h0000, 32'h0000_0000);
    // declared length shorter than the body
    send_request(REQ_BYTE, 8'h12, 1'b0, 9'd1, 16'h1234, 32'h1234_5678);
    send_request(REQ_BYTE, 8'h34, 1'b0, 9'd1, 16'h1234, 32'h1234_5678);
    send_request(REQ_BYTE, 8'h56, 1'b1, 9'd1, 16'h8000, 32'h8000_0000);
    // clear in the middle of a frame, with tlast set
    send_request(REQ_BYTE, 8'h77, 1'b0, 9'd3, 16'h0000, 32'h0000_0000);
    send_request(REQ_CLEAR, 8'hFF, 1'b1, 9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_BYTE, 8'h01, 1'b0, 9'd3, 16'h0000, 32'h0000_0000);
    send_request(REQ_BYTE, 8'h80, 1'b1, 9'd3, 16'hFFFF, 32'h0000_0001);
    // clear with tlast low, then a frame of only the last byte
    send_request(REQ_CLEAR, 8'h00, 1'b0, 9'd0, 16'h0000, 32'h0000_0000);
    send_request(REQ_BYTE, 8'hFF, 1'b1, 9'd511, 16'h0001, 32'h0000_0002);

    while (sent < ITEM_TARGET) begin
      if (!held && sent >= 400) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 800) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
      end
      if (sent >= 1150) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: stamp = stamp;
        1: stamp = $urandom;
        default: stamp = stamp + $urandom_range(1, 40);
      endcase
      pick = $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(0, 23);
      who = sender_pool[pick];
      if (!long_done && sent >= 600) begin
        long_done = 1'b1;
        send_frame(who, stamp, 600, -1, 9'd511);
      end else if ($urandom_range(0, 19) == 0) begin
        send_request(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                     9'($urandom), 16'($urandom), $urandom);
      end else begin
        body = $urandom_range(0, 8);
        lib = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0: flen = 9'($urandom);
          1: flen = 9'($urandom_range(0, body));
          2: flen = 9'(body + 1);
          default: flen = 9'(body);
        endcase
        send_frame(who, stamp, body, lib, flen);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TABLE_SIZE * 4) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/frf_pkg.sv
src/frf_ram.sv
src/frf_ctrl.sv
src/frf_dp.sv
src/frame_repetition_filter_core.sv
sim/frame_repetition_filter_core_tb.sv
